// ===== design/jan_pkg.sv =====
// ----------------------------------------------------------------------------
// jan_pkg
// shared widths, constants and lane control and result types for the joystick normalizer
// ----------------------------------------------------------------------------
package jan_pkg;

  localparam int ADC_W          = 12;     // raw converter reading
  localparam int DZ_W           = 10;     // deadzone and per-mille values
  localparam int POS_W          = 8;      // signed curved position
  localparam int MAG_W          = 7;      // curved magnitude 0..100
  localparam int ADC_FULL_SCALE = 4095;
  localparam int CAL_SAMPLES_DEF = 3;
  localparam int CENTER_RESET   = 2048;
  localparam int DZ_RESET       = 20;
  localparam int PERMILLE       = 1000;
  localparam int CURVE_DIV      = 10000;  // divide by 1000 then by 10

  // curve divide by reciprocal multiply: exact for squares below 2**20
  localparam int     CURVE_SHIFT = 34;
  localparam longint CURVE_RECIP = ((longint'(1) << CURVE_SHIFT) + CURVE_DIV - 1) / CURVE_DIV;
  localparam int     CRV_RECIP_W = 21;
  localparam int     CRV_PROD_W  = 2 * DZ_W + CRV_RECIP_W;

  // per-lane divider: dividend below divisor * 2**Q_W, two quotient bits a step
  localparam int NUM_W     = 22;
  localparam int DEN_W     = 16;
  localparam int Q_W       = 12;
  localparam int DIV_STEPS = Q_W / 2;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic start;   // load a new sample into the lane
    logic calib;   // sample is a calibration sample
    logic ack;     // merge stage has taken the lane result
  } lane_ctl_t;

  typedef struct packed {
    logic           done;   // result waits for the merge stage
    logic           upper;  // reading was above center
    logic [Q_W-1:0] value;  // new center or curved magnitude
  } lane_res_t;

endpackage

// ===== design/joystick_axis_normalizer.sv =====
// ----------------------------------------------------------------------------
// joystick_axis_normalizer
// two-axis joystick calibration, deadzone and square response curve
// ----------------------------------------------------------------------------
//
// channel  | dir | signals                    | contents
// ---------+-----+----------------------------+-------------------------------
// s_axis   | in  | tvalid tready tdata tuser  | tuser command, tdata x/y raw
// m_axis   | out | tvalid tready tdata        | x/y position, centered flag
// cfg      | in  | cfg_wr_en cfg_wr_data      | deadzone in per-mille
//
// for a position transaction each axis lane runs its divider once for the
// per-mille normalize (two quotient bits per cycle, plus load and handoff),
// then squares and applies the divide by 10000 as a reciprocal multiply
// a calibration transaction computes the center average by reciprocal
// multiply; a zero span ends a position before the divider starts, a deadzone
// hit before the square is divided by 10000
// one transaction is in flight at a time; s_axis_tready returns once the
// result is in the output register, so the next transaction overlaps a stalled
// output; a stalled result holds the lanes until the output register frees up
// rst is synchronous: centers go to 2048, sums and held positions to zero,
// deadzone to 20
// ----------------------------------------------------------------------------
module joystick_axis_normalizer import jan_pkg::*; #(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [23:0]     s_axis_tdata,   // x_raw[11:0], y_raw[23:12]
  input  logic            s_axis_tuser,   // command: 0 calibration, 1 position
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata,   // x_position[7:0], y_position[15:8],
                                          // centered[16], zero[23:17]
  input  logic            cfg_wr_en,
  input  logic [DZ_W-1:0] cfg_wr_data     // deadzone_permille
);

  localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
  localparam int SUM_W = ADC_W + CNT_W;

  // control state
  logic             busy;        // a transaction is in the lanes
  logic             cmd_pos;     // transaction in flight is a position sample
  logic             cal_final;   // transaction in flight closes a calibration
  logic [CNT_W-1:0] cal_count;
  logic             center_valid;
  logic [DZ_W-1:0]  deadzone;

  // calibration and output payload
  logic [SUM_W-1:0] sum_x, sum_y;
  logic [ADC_W-1:0] center_x, center_y;
  logic [POS_W-1:0] held_x, held_y;

  logic [ADC_W-1:0] x_raw, y_raw;
  logic [SUM_W-1:0] sum_x_next, sum_y_next;
  logic             accept, merge, last_cal;
  lane_ctl_t        ctl;
  lane_res_t        res_x, res_y;

  assign x_raw  = s_axis_tdata[ADC_W-1:0];
  assign y_raw  = s_axis_tdata[2*ADC_W-1:ADC_W];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // running sums including the sample being accepted
  assign sum_x_next = sum_x + SUM_W'(x_raw);
  assign sum_y_next = sum_y + SUM_W'(y_raw);
  assign last_cal   = (cal_count == CNT_W'(CAL_SAMPLES - 1));

  // merge stage: both lanes finished and the output register is free
  assign merge = busy && res_x.done && res_y.done && (!m_axis_tvalid || m_axis_tready);

  assign ctl.start = accept;
  assign ctl.calib = !s_axis_tuser;
  assign ctl.ack   = merge;

  jan_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_x (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .raw      (x_raw),
    .center   (center_x),
    .sum      (sum_x_next),
    .deadzone (deadzone),
    .res      (res_x)
  );

  jan_lane #(.CAL_SAMPLES(CAL_SAMPLES)) u_lane_y (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .raw      (y_raw),
    .center   (center_y),
    .sum      (sum_y_next),
    .deadzone (deadzone),
    .res      (res_y)
  );

  // sign the lane magnitudes: x positive above center, y positive below
  logic [POS_W-1:0] mag_x, mag_y, held_x_next, held_y_next;
  logic [ADC_W-1:0] center_x_next, center_y_next;
  logic             center_valid_next;

  always_comb begin
    mag_x             = POS_W'(res_x.value[MAG_W-1:0]);
    mag_y             = POS_W'(res_y.value[MAG_W-1:0]);
    held_x_next       = held_x;
    held_y_next       = held_y;
    center_x_next     = center_x;
    center_y_next     = center_y;
    center_valid_next = center_valid;
    if (cmd_pos) begin
      held_x_next = res_x.upper ? mag_x : -mag_x;
      held_y_next = res_y.upper ? -mag_y : mag_y;
    end else if (cal_final) begin
      center_x_next     = res_x.value;
      center_y_next     = res_y.value;
      center_valid_next = 1'b1;
    end
  end

  // control and calibration state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      cal_count     <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      center_x      <= ADC_W'(CENTER_RESET);
      center_y      <= ADC_W'(CENTER_RESET);
      center_valid  <= 1'b0;
      held_x        <= '0;
      held_y        <= '0;
      deadzone      <= DZ_W'(DZ_RESET);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) deadzone <= cfg_wr_data;

      if (accept) begin
        busy <= 1'b1;
        if (!s_axis_tuser) begin
          // the lanes divide the closing sums; the sums restart here
          if (last_cal) begin
            cal_count <= '0;
            sum_x     <= '0;
            sum_y     <= '0;
          end else begin
            cal_count <= cal_count + CNT_W'(1);
            sum_x     <= sum_x_next;
            sum_y     <= sum_y_next;
          end
        end
      end

      if (merge) begin
        busy          <= 1'b0;
        held_x        <= held_x_next;
        held_y        <= held_y_next;
        center_x      <= center_x_next;
        center_y      <= center_y_next;
        center_valid  <= center_valid_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // transaction attributes and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_pos   <= s_axis_tuser;
      cal_final <= !s_axis_tuser && last_cal;
    end
    if (merge) begin
      m_axis_tdata <= {7'b0, center_valid_next, held_y_next, held_x_next};
    end
  end

endmodule

// ===== design/jan_div.sv =====
// ----------------------------------------------------------------------------
// jan_div
// restoring divider, two quotient bits per cycle, fixed quotient width
// ----------------------------------------------------------------------------
module jan_div import jan_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DEN_W-1:0]  rem;
  logic [Q_W-1:0]    lo;
  logic [DEN_W-1:0]  den_q;

  logic [DEN_W:0] ra, ra_n, rb, rb_n;
  logic           ge_a, ge_b;

  always_comb begin
    ra   = {rem, lo[Q_W-1]};
    ge_a = ra >= {1'b0, den_q};
    ra_n = ge_a ? ra - {1'b0, den_q} : ra;
    rb   = {ra_n[DEN_W-1:0], lo[Q_W-2]};
    ge_b = rb >= {1'b0, den_q};
    rb_n = ge_b ? rb - {1'b0, den_q} : rb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem   <= {{(DEN_W - (NUM_W - Q_W)){1'b0}}, num[NUM_W-1:Q_W]};
      lo    <= num[Q_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem  <= rb_n[DEN_W-1:0];
      lo   <= {lo[Q_W-3:0], 2'b00};
      quot <= {quot[Q_W-3:0], ge_a, ge_b};
    end
  end

endmodule

// ===== design/jan_lane.sv =====
// ----------------------------------------------------------------------------
// jan_lane
// one axis: center average or span normalize, deadzone and square curve
// ----------------------------------------------------------------------------
module jan_lane import jan_pkg::*; #(
  parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  lane_ctl_t                              ctl,
  input  logic [ADC_W-1:0]                       raw,
  input  logic [ADC_W-1:0]                       center,
  input  logic [ADC_W+$clog2(CAL_SAMPLES+1)-1:0] sum,
  input  logic [DZ_W-1:0]                        deadzone,
  output lane_res_t                              res
);

  localparam int SUM_W = ADC_W + $clog2(CAL_SAMPLES + 1);

  // center average by reciprocal multiply, exact for every sum below 2**SUM_W
  localparam int CAL_SHIFT = SUM_W + $clog2(CAL_SAMPLES + 1);
  localparam int CAL_RECIP = (2 ** CAL_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int CPROD_W   = SUM_W + CAL_SHIFT + 1;
  localparam int SQ_W      = 2 * DZ_W;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SIDE = 3'd1;
  localparam logic [2:0] L_MUL  = 3'd2;
  localparam logic [2:0] L_DIV1 = 3'd3;
  localparam logic [2:0] L_SQR  = 3'd4;
  localparam logic [2:0] L_CURV = 3'd5;
  localparam logic [2:0] L_CDIV = 3'd6;
  localparam logic [2:0] L_DONE = 3'd7;

  logic [2:0]       state;
  logic             div_go;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [Q_W-1:0]   div_quot;

  logic [ADC_W-1:0] raw_q, cen_q, off;
  logic [SUM_W-1:0] sum_q;
  logic [DEN_W-1:0] span;
  logic             upper;
  logic [DZ_W-1:0]  pm;
  logic [SQ_W-1:0]  sq;
  logic [Q_W-1:0]   value;

  logic [CPROD_W-1:0]    cal_prod;
  logic [CRV_PROD_W-1:0] crv_prod;

  // side of center, span and clamped offset
  logic             upper_c;
  logic [DEN_W-1:0] cen_w, span_c;
  logic [ADC_W-1:0] off_c;

  always_comb begin
    cen_w   = DEN_W'(cen_q);
    upper_c = raw_q > cen_q;
    if (upper_c) begin
      span_c = (DEN_W'(ADC_FULL_SCALE) > cen_w) ? DEN_W'(ADC_FULL_SCALE) - cen_w : '0;
      off_c  = raw_q - cen_q;
    end else begin
      span_c = cen_w;
      off_c  = cen_q - raw_q;
    end
    if (DEN_W'(off_c) > span_c) begin
      off_c = span_c[ADC_W-1:0];
    end
  end

  // constant divides as reciprocal multiplies
  always_comb begin
    cal_prod = CPROD_W'(sum_q) * CPROD_W'(CAL_RECIP);
    crv_prod = CRV_PROD_W'(sq) * CRV_PROD_W'(CURVE_RECIP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        L_IDLE: begin
          if (ctl.start) begin
            if (ctl.calib) begin
              state <= L_CDIV;
            end else begin
              state <= L_SIDE;
            end
          end
        end
        L_SIDE: state <= L_MUL;
        L_MUL: begin
          if (span == '0) begin
            state <= L_DONE;
          end else begin
            div_go <= 1'b1;
            state  <= L_DIV1;
          end
        end
        L_DIV1: begin
          if (div_done) state <= L_SQR;
        end
        L_SQR: begin
          if (pm <= deadzone) begin
            state <= L_DONE;
          end else begin
            state <= L_CURV;
          end
        end
        L_CURV: state <= L_DONE;
        L_CDIV: state <= L_DONE;
        L_DONE: begin
          if (ctl.ack) state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (ctl.start) begin
          raw_q <= raw;
          cen_q <= center;
          sum_q <= sum;
        end
      end
      L_SIDE: begin
        upper <= upper_c;
        span  <= span_c;
        off   <= off_c;
      end
      L_MUL: begin
        value   <= '0;
        div_num <= NUM_W'(off) * NUM_W'(PERMILLE);
        div_den <= span;
      end
      L_DIV1: begin
        if (div_done) pm <= div_quot[DZ_W-1:0];
      end
      L_SQR: begin
        sq <= SQ_W'(pm) * SQ_W'(pm);
      end
      L_CURV: begin
        value <= Q_W'(crv_prod[CURVE_SHIFT +: MAG_W]);
      end
      L_CDIV: begin
        value <= cal_prod[CAL_SHIFT +: Q_W];
      end
      default: begin
      end
    endcase
  end

  jan_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  assign res.done  = (state == L_DONE);
  assign res.upper = upper;
  assign res.value = value;

endmodule

// ===== design/jan_checker.sv =====
// ----------------------------------------------------------------------------
// jan_checker
// port-level checks for the joystick normalizer, bound to the top level
// ----------------------------------------------------------------------------
module jan_checker import jan_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [23:0]     m_axis_tdata
);

  logic signed [POS_W-1:0] x_pos, y_pos;
  logic                    seen_centered;

  assign x_pos = m_axis_tdata[POS_W-1:0];
  assign y_pos = m_axis_tdata[2*POS_W-1:POS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_centered <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tdata[16]) begin
      seen_centered <= 1'b1;
    end
  end

  // stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  // one transaction in flight: ready drops right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a transaction is in flight");

  // curved positions stay within -100..100
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (x_pos >= -8'sd100) && (x_pos <= 8'sd100) &&
                      (y_pos >= -8'sd100) && (y_pos <= 8'sd100))
    else $error("position out of range");

  // once calibrated, every later result reports centered
  a_centered_sticky: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seen_centered |-> m_axis_tdata[16])
    else $error("centered flag dropped after calibration");

  // padding above the flag stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[23:17] == 7'b0)
    else $error("nonzero padding in output data");

endmodule

bind joystick_axis_normalizer jan_checker u_jan_checker (.*);
